// File: sv/utfg_pkg.sv
package utfg_pkg;

	typedef enum logic [1:0] {
		HS_NONE = 2'd0,
		HS_HW   = 2'd1,
		HS_AUTO = 2'd2
	} hs_mode_t;

	typedef enum logic [1:0] {
		CFG_HS_MODE    = 2'd0,
		CFG_FIFO_DEPTH = 2'd1,
		CFG_STOP_LIMIT = 2'd2
	} cfg_idx_t;

	localparam int CFG_W       = 20;
	localparam int FILL_W      = 5;
	localparam int LIMIT_W     = 20;
	localparam int RUN_W       = LIMIT_W + 1;
	localparam int CNT_W       = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 304;

	localparam logic [1:0]         HS_MODE_RST    = 2'd0;
	localparam logic [FILL_W-1:0]  FIFO_DEPTH_RST = 5'd16;
	localparam logic [LIMIT_W-1:0] STOP_LIMIT_RST = 20'd50000;

	// fields from the lowest bit up: cts, dsr, tx_empty, lock_held, tx_char
	typedef struct packed {
		logic [7:0] tx_char;
		logic       lock_held;
		logic       tx_empty;
		logic       dsr;
		logic       cts;
	} in_item_t;

	// packed MSB first, so sent lands in bit 0
	typedef struct packed {
		logic [CNT_W-1:0] blocked_sends;
		logic [CNT_W-1:0] fifo_wait_avg;
		logic [CNT_W-1:0] fifo_wait_max;
		logic [CNT_W-1:0] ready_wait_avg;
		logic [CNT_W-1:0] ready_wait_max;
		logic [CNT_W-1:0] hs_auto_go_polls;
		logic [CNT_W-1:0] hs_stop_events;
		logic [CNT_W-1:0] hs_stop_avg;
		logic [CNT_W-1:0] hs_stop_max;
		logic             hs_go;
		logic [7:0]       data_out;
		logic             sent;
	} out_item_t;

	// 16.16 iir step: a * (65536 - 16) / 65536 + v * 16, saturated
	function automatic logic [31:0] avg_fold(input logic [31:0] a, input logic [31:0] v);
		logic [52:0] t;
		t = {5'b0, a, 16'b0} - {17'b0, a, 4'b0} + {1'b0, v, 20'b0};
		if (|t[52:48]) begin
			return '1;
		end
		return t[47:16];
	endfunction

endpackage

// File: sv/uart_tx_flow_gate.sv
// channel  | signals                    | payload
// ---------+----------------------------+-------------------------------------------
// s        | s_tvalid s_tready s_tdata  | one poll: cts, dsr, tx_empty, lock_held, tx_char
// m        | m_tvalid m_tready m_tdata  | verdict, byte and statistics after that poll
// cfg      | cfg_wr_en cfg_idx cfg_wdata| flow mode, fifo_depth, stop_limit
//
// one poll per clock sustained while m takes results; a poll's result reaches m by way of
// the input register, then the combinational state update into the output register
// arst_n clears statistics and valids but not the data registers; fifo fill resets to 16
// a stalled m holds its result; s keeps taking polls until the input register is also full
module uart_tx_flow_gate
	import utfg_pkg::*;
#(
	parameter int MAX_FIFO_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // cts, dsr, tx_empty, lock_held, tx_char[7:0], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // sent, data_out[7:0], hs_go, hs_stop_max, hs_stop_avg,
	                                         // hs_stop_events, hs_auto_go_polls, ready_wait_max,
	                                         // ready_wait_avg, fifo_wait_max, fifo_wait_avg,
	                                         // blocked_sends, zero pad
	input  logic                   cfg_wr_en,
	input  logic [1:0]             cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	hs_mode_t             hs_mode_q;
	logic [FILL_W-1:0]    fifo_depth_q;
	logic [LIMIT_W-1:0]   stop_limit_q;

	in_item_t             item_s1;
	logic                 vld_s1;
	out_item_t            out_q;
	logic                 out_vld_q;
	logic                 adv;

	logic [FILL_W-1:0]    fifo_fill_q, fifo_fill_d;
	logic [RUN_W-1:0]     stop_run_q, stop_run_d;
	logic [RUN_W-1:0]     stop_max_q, stop_max_d;
	logic [CNT_W-1:0]     stop_avg_q, stop_avg_d;
	logic [CNT_W-1:0]     stop_events_q, stop_events_d;
	logic [CNT_W-1:0]     auto_go_q, auto_go_d;
	logic [CNT_W-1:0]     cur_ready_wait_q, cur_ready_wait_d;
	logic [CNT_W-1:0]     cur_fifo_wait_q, cur_fifo_wait_d;
	logic                 cur_locked_q, cur_locked_d;
	logic [CNT_W-1:0]     ready_max_q, ready_max_d;
	logic [CNT_W-1:0]     ready_avg_q, ready_avg_d;
	logic [CNT_W-1:0]     fifo_max_q, fifo_max_d;
	logic [CNT_W-1:0]     fifo_avg_q, fifo_avg_d;
	logic [CNT_W-1:0]     blocked_q, blocked_d;

	logic [FILL_W-1:0]    depth;
	logic [FILL_W-1:0]    fill_eff;
	logic [RUN_W-1:0]     limit_ext;
	logic                 go;
	logic                 full;
	logic                 ready;
	out_item_t            out_d;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_mode_q    <= hs_mode_t'(HS_MODE_RST);
			fifo_depth_q <= FIFO_DEPTH_RST;
			stop_limit_q <= STOP_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_HS_MODE:    hs_mode_q    <= hs_mode_t'(cfg_wdata[1:0]);
				CFG_FIFO_DEPTH: fifo_depth_q <= cfg_wdata[FILL_W-1:0];
				CFG_STOP_LIMIT: stop_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
		if (adv) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		depth = fifo_depth_q;
		if (32'(fifo_depth_q) > MAX_FIFO_DEPTH) begin
			depth = FILL_W'(MAX_FIFO_DEPTH);
		end
		fill_eff  = item_s1.tx_empty ? '0 : fifo_fill_q;
		limit_ext = {1'b0, stop_limit_q};

		go            = 1'b1;
		stop_run_d    = stop_run_q;
		stop_max_d    = stop_max_q;
		stop_avg_d    = stop_avg_q;
		stop_events_d = stop_events_q;
		auto_go_d     = auto_go_q;
		if (hs_mode_q == HS_HW || hs_mode_q == HS_AUTO) begin
			if (item_s1.cts && item_s1.dsr) begin
				stop_avg_d = avg_fold(stop_avg_q, CNT_W'(stop_run_q));
				stop_run_d = '0;
			end else if (stop_run_q >= limit_ext) begin
				if (hs_mode_q == HS_AUTO) begin
					auto_go_d = auto_go_q + 1'b1;
					if (stop_run_q == limit_ext) begin
						stop_avg_d = avg_fold(stop_avg_q, CNT_W'(stop_run_q));
						stop_run_d = stop_run_q + 1'b1;
					end
				end else begin
					go = 1'b0;
				end
			end else begin
				go = 1'b0;
				if (stop_run_q == '0) begin
					stop_events_d = stop_events_q + 1'b1;
				end
				stop_run_d = stop_run_q + 1'b1;
				if (stop_run_d > stop_max_q) begin
					stop_max_d = stop_run_d;
				end
			end
		end

		full  = fill_eff >= depth;
		ready = go && !full && !item_s1.lock_held;

		fifo_fill_d      = fill_eff;
		cur_ready_wait_d = cur_ready_wait_q;
		cur_fifo_wait_d  = cur_fifo_wait_q + CNT_W'(go && full);
		cur_locked_d     = cur_locked_q || (go && !full && item_s1.lock_held);
		ready_max_d      = ready_max_q;
		ready_avg_d      = ready_avg_q;
		fifo_max_d       = fifo_max_q;
		fifo_avg_d       = fifo_avg_q;
		blocked_d        = blocked_q;
		if (!ready) begin
			cur_ready_wait_d = cur_ready_wait_q + 1'b1;
		end else begin
			if (cur_ready_wait_q > ready_max_q) begin
				ready_max_d = cur_ready_wait_q;
			end
			ready_avg_d = avg_fold(ready_avg_q, cur_ready_wait_q);
			if (cur_fifo_wait_q > fifo_max_q) begin
				fifo_max_d = cur_fifo_wait_q;
			end
			fifo_avg_d       = avg_fold(fifo_avg_q, cur_fifo_wait_q);
			fifo_fill_d      = fill_eff + 1'b1;
			blocked_d        = blocked_q + CNT_W'(cur_locked_q);
			cur_ready_wait_d = '0;
			cur_fifo_wait_d  = '0;
			cur_locked_d     = 1'b0;
		end

		out_d.sent             = ready;
		out_d.data_out         = ready ? item_s1.tx_char : 8'd0;
		out_d.hs_go            = go;
		out_d.hs_stop_max      = CNT_W'(stop_max_d);
		out_d.hs_stop_avg      = stop_avg_d;
		out_d.hs_stop_events   = stop_events_d;
		out_d.hs_auto_go_polls = auto_go_d;
		out_d.ready_wait_max   = ready_max_d;
		out_d.ready_wait_avg   = ready_avg_d;
		out_d.fifo_wait_max    = fifo_max_d;
		out_d.fifo_wait_avg    = fifo_avg_d;
		out_d.blocked_sends    = blocked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_fill_q      <= FIFO_DEPTH_RST;
			stop_run_q       <= '0;
			stop_max_q       <= '0;
			stop_avg_q       <= '0;
			stop_events_q    <= '0;
			auto_go_q        <= '0;
			cur_ready_wait_q <= '0;
			cur_fifo_wait_q  <= '0;
			cur_locked_q     <= 1'b0;
			ready_max_q      <= '0;
			ready_avg_q      <= '0;
			fifo_max_q       <= '0;
			fifo_avg_q       <= '0;
			blocked_q        <= '0;
		end else if (adv) begin
			fifo_fill_q      <= fifo_fill_d;
			stop_run_q       <= stop_run_d;
			stop_max_q       <= stop_max_d;
			stop_avg_q       <= stop_avg_d;
			stop_events_q    <= stop_events_d;
			auto_go_q        <= auto_go_d;
			cur_ready_wait_q <= cur_ready_wait_d;
			cur_fifo_wait_q  <= cur_fifo_wait_d;
			cur_locked_q     <= cur_locked_d;
			ready_max_q      <= ready_max_d;
			ready_avg_q      <= ready_avg_d;
			fifo_max_q       <= fifo_max_d;
			fifo_avg_q       <= fifo_avg_d;
			blocked_q        <= blocked_d;
		end
	end

	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(vld_s1))
		else $error("result appeared without a stage 1 poll");

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ready |=> cur_ready_wait_q == '0 && cur_fifo_wait_q == '0 && !cur_locked_q)
		else $error("wait counters not cleared after a send");

	a_sent_needs_go: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.sent |-> out_q.hs_go)
		else $error("byte sent while handshake said stop");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(fifo_fill_q) && $stable(stop_run_q) && $stable(cur_ready_wait_q))
		else $error("poll state moved without a transaction");

endmodule

// File: test/uart_tx_flow_gate_tb.sv
`timescale 1ns / 1ps

module uart_tx_flow_gate_tb;
	import utfg_pkg::*;

	localparam int MAX_DEPTH = 16;
	localparam int QUIET_LIMIT = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_POLLS = 200;
	localparam int PHASE_COUNT = 8;
	localparam logic [1:0] HS_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_wr_en;
	logic [1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	// gate state as the testbench sees it
	logic [1:0] mode_r;
	logic [4:0] depth_r;
	logic [19:0] limit_r;
	logic [4:0] fill;
	logic [31:0] run_len, run_max, run_avg, run_events, forced_go;
	logic [31:0] wait_polls, full_polls;
	logic lock_seen;
	logic [31:0] wait_max, wait_avg, full_max, full_avg, lock_sends;

	out_item_t exp_status[$];
	int fail_cnt = 0;
	int quiet = 0;
	bit s_burst = 0;
	bit m_burst = 0;

	uart_tx_flow_gate uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [31:0] iir_step(logic [31:0] acc, logic [31:0] sample);
		logic [63:0] t;
		t = (64'd65520 * 64'(acc) + (64'(sample) << 20)) >> 16;
		return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	function automatic out_item_t predict_poll(in_item_t p);
		out_item_t r;
		logic go, ready;
		logic [4:0] lim_depth;
		lim_depth = (depth_r > MAX_DEPTH) ? 5'(MAX_DEPTH) : depth_r;
		if (p.tx_empty) fill = '0;
		if (mode_r != HS_HW && mode_r != HS_AUTO) begin
			go = 1'b1;
		end else if (p.cts && p.dsr) begin
			run_avg = iir_step(run_avg, run_len);
			run_len = '0;
			go = 1'b1;
		end else if (run_len >= 32'(limit_r)) begin
			if (mode_r == HS_AUTO) begin
				forced_go++;
				if (run_len == 32'(limit_r)) begin
					run_avg = iir_step(run_avg, run_len);
					run_len++;
				end
				go = 1'b1;
			end else begin
				go = 1'b0;
			end
		end else begin
			if (run_len == 0) run_events++;
			run_len++;
			if (run_len > run_max) run_max = run_len;
			go = 1'b0;
		end
		ready = go;
		if (ready && fill >= lim_depth) begin
			ready = 1'b0;
			full_polls++;
		end
		if (ready && p.lock_held) begin
			ready = 1'b0;
			lock_seen = 1'b1;
		end
		if (!ready) begin
			wait_polls++;
		end else begin
			if (wait_polls > wait_max) wait_max = wait_polls;
			wait_avg = iir_step(wait_avg, wait_polls);
			if (full_polls > full_max) full_max = full_polls;
			full_avg = iir_step(full_avg, full_polls);
			fill = fill + 5'd1;
			if (lock_seen) lock_sends++;
			wait_polls = '0;
			full_polls = '0;
			lock_seen = 1'b0;
		end
		r = '0;
		r.sent = ready;
		r.data_out = ready ? p.tx_char : 8'h00;
		r.hs_go = go;
		r.hs_stop_max = run_max;
		r.hs_stop_avg = run_avg;
		r.hs_stop_events = run_events;
		r.hs_auto_go_polls = forced_go;
		r.ready_wait_max = wait_max;
		r.ready_wait_avg = wait_avg;
		r.fifo_wait_max = full_max;
		r.fifo_wait_avg = full_avg;
		r.blocked_sends = lock_sends;
		return r;
	endfunction

	function automatic in_item_t mk_poll(bit cts, bit dsr, bit empty, bit lock, logic [7:0] ch);
		in_item_t p;
		p.cts = cts;
		p.dsr = dsr;
		p.tx_empty = empty;
		p.lock_held = lock;
		p.tx_char = ch;
		return p;
	endfunction

	task automatic issue_poll(in_item_t p);
		int gap;
		gap = s_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(p);
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		exp_status.push_back(predict_poll(p));
		if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (exp_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_HS_MODE: mode_r = val[1:0];
			CFG_FIFO_DEPTH: depth_r = val[4:0];
			CFG_STOP_LIMIT: limit_r = val[19:0];
			default: ;
		endcase
	endtask

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// result side: random stalls, check every transaction against the oldest prediction
	initial begin
		int stall;
		out_item_t got, want;
		m_tready <= 1'b0;
		forever begin
			stall = m_burst ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
			if (exp_status.size() == 0) begin
				$error("status transaction with nothing expected");
				fail_cnt++;
			end else begin
				want = exp_status.pop_front();
				cmp_field("sent", 32'(want.sent), 32'(got.sent));
				cmp_field("data_out", 32'(want.data_out), 32'(got.data_out));
				cmp_field("hs_go", 32'(want.hs_go), 32'(got.hs_go));
				cmp_field("hs_stop_max", want.hs_stop_max, got.hs_stop_max);
				cmp_field("hs_stop_avg", want.hs_stop_avg, got.hs_stop_avg);
				cmp_field("hs_stop_events", want.hs_stop_events, got.hs_stop_events);
				cmp_field("hs_auto_go_polls", want.hs_auto_go_polls, got.hs_auto_go_polls);
				cmp_field("ready_wait_max", want.ready_wait_max, got.ready_wait_max);
				cmp_field("ready_wait_avg", want.ready_wait_avg, got.ready_wait_avg);
				cmp_field("fifo_wait_max", want.fifo_wait_max, got.fifo_wait_max);
				cmp_field("fifo_wait_avg", want.fifo_wait_avg, got.fifo_wait_avg);
				cmp_field("blocked_sends", want.blocked_sends, got.blocked_sends);
			end
			if ($urandom_range(0, 49) == 0) m_burst = !m_burst;
		end
	end

	task automatic test_no_handshake();
		// reset fill equals depth, so the first poll waits on the fifo
		issue_poll(mk_poll(0, 0, 0, 0, 8'hA5));
		issue_poll(mk_poll(0, 0, 1, 0, 8'h00));
		issue_poll(mk_poll(1, 1, 1, 1, 8'hFF));
		issue_poll(mk_poll(1, 0, 0, 0, 8'hFF));
		write_reg(CFG_HS_MODE, {18'd0, HS_UNUSED});
		issue_poll(mk_poll(0, 1, 1, 0, 8'h5A));
	endtask

	task automatic test_hw_flow();
		write_reg(CFG_HS_MODE, {18'd0, HS_HW});
		write_reg(CFG_STOP_LIMIT, 20'd2);
		issue_poll(mk_poll(0, 1, 1, 0, 8'h11));
		issue_poll(mk_poll(0, 0, 1, 0, 8'h22));
		// held at the limit
		issue_poll(mk_poll(0, 1, 1, 0, 8'h33));
		issue_poll(mk_poll(1, 0, 1, 0, 8'h44));
		issue_poll(mk_poll(1, 1, 1, 0, 8'h55));
		write_reg(CFG_STOP_LIMIT, 20'd0);
		issue_poll(mk_poll(0, 0, 1, 0, 8'h66));
		issue_poll(mk_poll(1, 1, 1, 0, 8'h77));
	endtask

	task automatic test_auto_release();
		write_reg(CFG_HS_MODE, {18'd0, HS_AUTO});
		write_reg(CFG_STOP_LIMIT, 20'd2);
		issue_poll(mk_poll(0, 0, 1, 0, 8'h81));
		issue_poll(mk_poll(0, 1, 1, 0, 8'h82));
		issue_poll(mk_poll(1, 0, 1, 0, 8'h83));
		issue_poll(mk_poll(0, 0, 1, 0, 8'h84));
		issue_poll(mk_poll(1, 1, 1, 0, 8'h85));
	endtask

	task automatic test_fifo_limits();
		write_reg(CFG_HS_MODE, {18'd0, HS_NONE});
		write_reg(CFG_FIFO_DEPTH, 20'd1);
		issue_poll(mk_poll(1, 1, 1, 0, 8'hC1));
		issue_poll(mk_poll(1, 1, 0, 0, 8'hC2));
		issue_poll(mk_poll(1, 1, 1, 0, 8'hC3));
		write_reg(CFG_FIFO_DEPTH, 20'd0);
		issue_poll(mk_poll(1, 1, 1, 0, 8'hC4));
		write_reg(CFG_FIFO_DEPTH, 20'd31);
		issue_poll(mk_poll(1, 1, 1, 0, 8'hC5));
		write_reg(CFG_UNUSED, 20'hFFFFF);
		issue_poll(mk_poll(1, 1, 0, 0, 8'hC6));
	endtask

	task automatic test_random_traffic();
		logic [1:0] mode;
		logic [4:0] depth;
		logic [19:0] limit;
		int stop_left;
		bit cts, dsr, empty, lock;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin mode = HS_NONE; depth = 5'd16; limit = 20'd50000; end
				1: begin mode = HS_HW; depth = 5'd1; limit = 20'd4; end
				2: begin mode = HS_AUTO; depth = 5'd16; limit = 20'd3; end
				3: begin mode = HS_AUTO; depth = 5'd1; limit = 20'd1; end
				4: begin mode = HS_HW; depth = 5'd16; limit = 20'hFFFFF; end
				default: begin
					mode = 2'($urandom_range(0, 3));
					depth = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
						(($urandom_range(0, 1) == 0) ? 5'd1 : 5'd16);
					limit = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
						20'($urandom_range(0, 10));
				end
			endcase
			write_reg(CFG_HS_MODE, {18'($urandom), mode});
			write_reg(CFG_FIFO_DEPTH, {15'($urandom), depth});
			write_reg(CFG_STOP_LIMIT, limit);
			if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 20'($urandom));
			stop_left = 0;
			for (int n = 0; n < PHASE_POLLS; n++) begin
				if (ph == 0 && n == PHASE_POLLS / 2) wait_idle();
				if (stop_left == 0 && $urandom_range(0, 5) == 0)
					stop_left = $urandom_range(1, 12);
				if (stop_left > 0) begin
					case ($urandom_range(0, 2))
						0: begin cts = 1'b0; dsr = 1'b0; end
						1: begin cts = 1'b0; dsr = 1'b1; end
						default: begin cts = 1'b1; dsr = 1'b0; end
					endcase
					stop_left--;
				end else if ($urandom_range(0, 19) == 0) begin
					cts = 1'($urandom_range(0, 1));
					dsr = 1'($urandom_range(0, 1));
				end else begin
					cts = 1'b1;
					dsr = 1'b1;
				end
				empty = ($urandom_range(0, 99) < 30);
				lock = ($urandom_range(0, 99) < 15);
				issue_poll(mk_poll(cts, dsr, empty, lock, 8'($urandom)));
			end
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_idx <= CFG_HS_MODE;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		mode_r = HS_MODE_RST;
		depth_r = FIFO_DEPTH_RST;
		limit_r = STOP_LIMIT_RST;
		fill = FIFO_DEPTH_RST;
		run_len = '0;
		run_max = '0;
		run_avg = '0;
		run_events = '0;
		forced_go = '0;
		wait_polls = '0;
		full_polls = '0;
		lock_seen = 1'b0;
		wait_max = '0;
		wait_avg = '0;
		full_max = '0;
		full_avg = '0;
		lock_sends = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_handshake();
		test_hw_flow();
		test_auto_release();
		test_fifo_limits();
		test_random_traffic();
		wait_idle();
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
